// ===== rtl/core/tasm_pkg.sv =====
// ----------------------------------------------------------------------------
// tasm_pkg
// shared types, widths and codes for the triangle affine solve and map block
// ----------------------------------------------------------------------------
package tasm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int FIX_ONE      = 1 << FRAC_BITS;
    localparam int VW           = 32;
    localparam int NVAL         = 6;
    localparam int NMUL         = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int DATA_W       = VW * NVAL;

    localparam int PW           = 2 * VW + 1;
    localparam int DPW          = 2 * VW + 2;
    localparam int KPW          = 2 * VW;
    localparam int LW           = 2 * VW + 3;
    localparam int KW           = 2 * VW + 1;
    localparam int KSPLIT       = 33;
    localparam int NW           = 100;
    localparam int DW           = 68;
    localparam int NDW          = NW + 1;
    localparam int DDW          = DW;
    localparam int QW           = 32;

    localparam int FRONT_STAGES = 6;
    localparam int DIV_STAGES   = QW + 1;

    typedef enum logic {
        REQ_SOLVE = 1'b0,
        REQ_MAP   = 1'b1
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5
    } cfg_idx_t;

    typedef logic signed [VW-1:0]     val_t;
    typedef logic signed [VW:0]       dif_t;
    typedef logic signed [KSPLIT:0]   kl_t;
    typedef logic signed [PW-1:0]     prod_t;
    typedef logic signed [DPW-1:0]    dp_t;
    typedef logic signed [KPW-1:0]    kp_t;
    typedef logic signed [LW-1:0]     lin_t;
    typedef logic signed [KW-1:0]     k_t;
    typedef logic signed [NW-1:0]     num_t;
    typedef logic signed [DW-1:0]     den_t;
    typedef logic [NVAL-1:0][VW-1:0]  val_vec_t;

    typedef struct packed {
        val_t ax;
        val_t ay;
        val_t bx;
        val_t by;
        val_t cx;
        val_t cy;
    } basis_t;

    localparam basis_t BASIS_RST = '{
        ax: '0, ay: '0, bx: val_t'(FIX_ONE), by: '0, cx: '0, cy: val_t'(FIX_ONE)
    };

    typedef struct packed {
        logic [NVAL-1:0][NDW-1:0] nd;
        logic [DDW-1:0]           dd;
        logic [NVAL-1:0]          neg;
        logic                     degen;
    } div_req_t;

    typedef struct packed {
        logic [NVAL-1:0][QW-1:0] q;
        logic [NVAL-1:0]         neg;
        logic [NVAL-1:0]         ovf;
        logic                    degen;
    } div_res_t;

endpackage

// ===== rtl/core/tasm_front.sv =====
// ----------------------------------------------------------------------------
// tasm_front
// products, sums and sign split that turn a request into six divisions
// ----------------------------------------------------------------------------
module tasm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tasm_pkg::req_t     in_req,
    input  tasm_pkg::val_vec_t in_val,
    input  tasm_pkg::basis_t   basis,
    output logic               out_valid,
    input  logic               out_ready,
    output tasm_pkg::div_req_t out_req
);
    import tasm_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;
    logic [FRONT_STAGES-1:0] en;

    req_t     s1_req_reg;
    val_t     s1_val_reg [NVAL];

    dif_t     dy [3];
    dif_t     dx [3];
    val_t     px [3];
    val_t     py [3];
    dif_t     dca_x;
    dif_t     dba_y;
    dif_t     cf [4];
    val_t     mul_a [NMUL];
    dif_t     mul_b [NMUL];
    prod_t    s2_prod_next [NMUL];
    dp_t      s2_detp_next [2];
    kp_t      s2_kp_next [6];

    req_t     s2_req_reg;
    val_t     s2_val_reg [NVAL];
    prod_t    s2_prod_reg [NMUL];
    dp_t      s2_detp_reg [2];
    kp_t      s2_kp_reg [6];

    lin_t     off [2];
    lin_t     s3_lin_next [4];
    lin_t     s3_nxy_next [6];
    lin_t     s3_det_next;
    k_t       s3_k_next [3];

    req_t     s3_req_reg;
    val_t     s3_val_reg [NVAL];
    lin_t     s3_lin_reg [4];
    lin_t     s3_nxy_reg [6];
    lin_t     s3_det_reg;
    k_t       s3_k_reg [3];

    val_t     kh [3];
    kl_t      kl [3];
    kp_t      s4_ph_next [6];
    dp_t      s4_pl_next [6];

    req_t     s4_req_reg;
    lin_t     s4_lin_reg [4];
    lin_t     s4_nxy_reg [6];
    lin_t     s4_det_reg;
    kp_t      s4_ph_reg [6];
    dp_t      s4_pl_reg [6];

    num_t     cst [2];
    num_t     s5_num_next [NVAL];
    den_t     s5_den_next;
    logic     s5_degen_next;

    num_t     s5_num_reg [NVAL];
    den_t     s5_den_reg;
    logic     s5_degen_reg;

    logic [NW-1:0] mag [NVAL];
    logic [DW-1:0] dmag;
    div_req_t      out_req_next;
    div_req_t      out_req_reg;

    // stall chain
    always_comb
    begin
        en[FRONT_STAGES-1] = !vld_reg[FRONT_STAGES-1] || out_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < FRONT_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_req   = out_req_reg;

    // stage 1 to 2: all narrow products
    always_comb
    begin
        int m;
        dy[0] = dif_t'(basis.by) - dif_t'(basis.cy);
        dy[1] = dif_t'(basis.cy) - dif_t'(basis.ay);
        dy[2] = dif_t'(basis.ay) - dif_t'(basis.by);
        dx[0] = dif_t'(basis.cx) - dif_t'(basis.bx);
        dx[1] = dif_t'(basis.ax) - dif_t'(basis.cx);
        dx[2] = dif_t'(basis.bx) - dif_t'(basis.ax);
        dca_x = dif_t'(basis.cx) - dif_t'(basis.ax);
        dba_y = dif_t'(basis.by) - dif_t'(basis.ay);
        px[0] = basis.ax;
        px[1] = basis.bx;
        px[2] = basis.cx;
        py[0] = basis.ay;
        py[1] = basis.by;
        py[2] = basis.cy;
        cf[0] = dif_t'(s1_val_reg[0]);
        cf[1] = -dif_t'(s1_val_reg[2]);
        cf[2] = -dif_t'(s1_val_reg[1]);
        cf[3] = dif_t'(s1_val_reg[3]);
        for (int o = 0; o < 2; o++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m = o * 6 + j * 3 + i;
                    if (s1_req_reg == REQ_SOLVE)
                    begin
                        mul_a[m] = s1_val_reg[2*i+o];
                        mul_b[m] = (j == 1) ? dx[i] : dy[i];
                    end
                    else
                    begin
                        mul_a[m] = (j == 1) ? py[i] : px[i];
                        mul_b[m] = cf[o*2+j];
                    end
                    s2_prod_next[m] = mul_a[m] * mul_b[m];
                end
            end
        end
        s2_detp_next[0] = dx[2] * dy[1];
        s2_detp_next[1] = dca_x * dba_y;
        s2_kp_next[0]   = basis.bx * basis.cy;
        s2_kp_next[1]   = basis.by * basis.cx;
        s2_kp_next[2]   = basis.ay * basis.cx;
        s2_kp_next[3]   = basis.ax * basis.cy;
        s2_kp_next[4]   = basis.ax * basis.by;
        s2_kp_next[5]   = basis.ay * basis.bx;
    end

    // stage 2 to 3: sums
    always_comb
    begin
        off[0] = lin_t'(s2_val_reg[4]) <<< FRAC_BITS;
        off[1] = -(lin_t'(s2_val_reg[5]) <<< FRAC_BITS);
        for (int o = 0; o < 2; o++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                s3_lin_next[o*2+j] = lin_t'(s2_prod_reg[o*6+j*3])
                                   + lin_t'(s2_prod_reg[o*6+j*3+1])
                                   + lin_t'(s2_prod_reg[o*6+j*3+2]);
            end
            for (int i = 0; i < 3; i++)
            begin
                s3_nxy_next[o*3+i] = lin_t'(s2_prod_reg[o*6+i])
                                   + lin_t'(s2_prod_reg[o*6+3+i]) + off[o];
            end
        end
        s3_det_next = lin_t'(s2_detp_reg[0]) - lin_t'(s2_detp_reg[1]);
        for (int i = 0; i < 3; i++)
        begin
            s3_k_next[i] = k_t'(s2_kp_reg[2*i]) - k_t'(s2_kp_reg[2*i+1]);
        end
    end

    // stage 3 to 4: target times corner terms, split in two halves
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kh[i] = $signed(s3_k_reg[i][KW-1:KSPLIT]);
            kl[i] = $signed({1'b0, s3_k_reg[i][KSPLIT-1:0]});
        end
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_ph_next[c*3+i] = s3_val_reg[2*i+c] * kh[i];
                s4_pl_next[c*3+i] = s3_val_reg[2*i+c] * kl[i];
            end
        end
    end

    // stage 4 to 5: numerators and divisor
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            cst[c] = '0;
            for (int i = 0; i < 3; i++)
            begin
                cst[c] = cst[c] + (num_t'(s4_ph_reg[c*3+i]) <<< KSPLIT)
                       + num_t'(s4_pl_reg[c*3+i]);
            end
        end
        if (s4_req_reg == REQ_SOLVE)
        begin
            s5_num_next[0] = num_t'(s4_lin_reg[0]) <<< FRAC_BITS;
            s5_num_next[1] = -(num_t'(s4_lin_reg[2]) <<< FRAC_BITS);
            s5_num_next[2] = -(num_t'(s4_lin_reg[1]) <<< FRAC_BITS);
            s5_num_next[3] = num_t'(s4_lin_reg[3]) <<< FRAC_BITS;
            s5_num_next[4] = cst[0];
            s5_num_next[5] = -cst[1];
            s5_den_next    = den_t'(s4_det_reg);
            s5_degen_next  = (s4_det_reg == '0);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_num_next[2*i]   = num_t'(s4_nxy_reg[i]);
                s5_num_next[2*i+1] = num_t'(s4_nxy_reg[3+i]);
            end
            s5_den_next   = den_t'(FIX_ONE);
            s5_degen_next = 1'b0;
        end
    end

    // stage 5 to 6: magnitudes, rounding offset, signs
    always_comb
    begin
        dmag = s5_den_reg[DW-1] ? DW'(-s5_den_reg) : DW'(s5_den_reg);
        for (int j = 0; j < NVAL; j++)
        begin
            mag[j] = s5_num_reg[j][NW-1] ? NW'(-s5_num_reg[j]) : NW'(s5_num_reg[j]);
            out_req_next.nd[j]  = (NDW'(mag[j]) << 1) + NDW'(dmag);
            out_req_next.neg[j] = s5_num_reg[j][NW-1] ^ s5_den_reg[DW-1];
        end
        out_req_next.dd    = DDW'(dmag << 1);
        out_req_next.degen = s5_degen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_req_reg <= in_req;
            for (int j = 0; j < NVAL; j++)
            begin
                s1_val_reg[j] <= val_t'(in_val[j]);
            end
        end
        if (en[1])
        begin
            s2_req_reg   <= s1_req_reg;
            s2_val_reg   <= s1_val_reg;
            s2_prod_reg  <= s2_prod_next;
            s2_detp_reg  <= s2_detp_next;
            s2_kp_reg    <= s2_kp_next;
        end
        if (en[2])
        begin
            s3_req_reg <= s2_req_reg;
            s3_val_reg <= s2_val_reg;
            s3_lin_reg <= s3_lin_next;
            s3_nxy_reg <= s3_nxy_next;
            s3_det_reg <= s3_det_next;
            s3_k_reg   <= s3_k_next;
        end
        if (en[3])
        begin
            s4_req_reg <= s3_req_reg;
            s4_lin_reg <= s3_lin_reg;
            s4_nxy_reg <= s3_nxy_reg;
            s4_det_reg <= s3_det_reg;
            s4_ph_reg  <= s4_ph_next;
            s4_pl_reg  <= s4_pl_next;
        end
        if (en[4])
        begin
            s5_num_reg   <= s5_num_next;
            s5_den_reg   <= s5_den_next;
            s5_degen_reg <= s5_degen_next;
        end
        if (en[5])
        begin
            out_req_reg <= out_req_next;
        end
    end

endmodule

// ===== rtl/core/tasm_div.sv =====
// ----------------------------------------------------------------------------
// tasm_div
// six pipelined restoring dividers, an overflow check stage, then one quotient bit per stage
// ----------------------------------------------------------------------------
module tasm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tasm_pkg::div_req_t in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output tasm_pkg::div_res_t out_res
);
    import tasm_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_next;
    logic [DIV_STAGES-1:0] en;

    logic [NDW-1:0]  rem_reg   [DIV_STAGES][NVAL];
    logic [NDW-1:0]  rem_next  [DIV_STAGES][NVAL];
    logic [NDW-1:0]  trial     [DIV_STAGES][NVAL];
    logic [QW-1:0]   q_reg     [DIV_STAGES][NVAL];
    logic [QW-1:0]   q_next    [DIV_STAGES][NVAL];
    logic [DDW-1:0]  dd_reg    [DIV_STAGES];
    logic [NVAL-1:0] neg_reg   [DIV_STAGES];
    logic [NVAL-1:0] ovf_reg   [DIV_STAGES];
    logic [NVAL-1:0] ovf_next;
    logic            degen_reg [DIV_STAGES];

    always_comb
    begin
        en[DIV_STAGES-1] = !vld_reg[DIV_STAGES-1] || out_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // quotient of 2^32 or more saturates in any case
    always_comb
    begin
        for (int j = 0; j < NVAL; j++)
        begin
            trial[0][j]  = NDW'(in_req.dd) << QW;
            ovf_next[j]  = (in_req.nd[j] >= trial[0][j]);
            rem_next[0][j] = in_req.nd[j];
            q_next[0][j]   = '0;
        end
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            for (int j = 0; j < NVAL; j++)
            begin
                trial[s][j] = NDW'(dd_reg[s-1]) << (QW - s);
                if (rem_reg[s-1][j] >= trial[s][j])
                begin
                    rem_next[s][j] = rem_reg[s-1][j] - trial[s][j];
                    q_next[s][j]   = q_reg[s-1][j] | (QW'(1) << (QW - s));
                end
                else
                begin
                    rem_next[s][j] = rem_reg[s-1][j];
                    q_next[s][j]   = q_reg[s-1][j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                if (s == 0)
                begin
                    dd_reg[0]    <= in_req.dd;
                    neg_reg[0]   <= in_req.neg;
                    ovf_reg[0]   <= ovf_next;
                    degen_reg[0] <= in_req.degen;
                end
                else
                begin
                    dd_reg[s]    <= dd_reg[s-1];
                    neg_reg[s]   <= neg_reg[s-1];
                    ovf_reg[s]   <= ovf_reg[s-1];
                    degen_reg[s] <= degen_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NVAL; j++)
        begin
            out_res.q[j] = q_reg[DIV_STAGES-1][j];
        end
        out_res.neg   = neg_reg[DIV_STAGES-1];
        out_res.ovf   = ovf_reg[DIV_STAGES-1];
        out_res.degen = degen_reg[DIV_STAGES-1];
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/tasm_sat.sv =====
// ----------------------------------------------------------------------------
// tasm_sat
// sign restore, clamp to 32 bits and output register
// ----------------------------------------------------------------------------
module tasm_sat (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tasm_pkg::div_res_t in_res,
    output logic               out_valid,
    input  logic               out_ready,
    output tasm_pkg::val_vec_t out_val,
    output logic               out_degen,
    output logic               out_sat
);
    import tasm_pkg::*;

    localparam val_t VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    logic     valid_reg;
    logic     valid_next;
    val_vec_t val_reg;
    val_vec_t val_next;
    logic     degen_reg;
    logic     sat_reg;
    logic     sat_next;

    always_comb
    begin
        sat_next = 1'b0;
        for (int j = 0; j < NVAL; j++)
        begin
            if (in_res.degen)
            begin
                val_next[j] = '0;
            end
            else if (!in_res.neg[j])
            begin
                if (in_res.ovf[j] || in_res.q[j][QW-1])
                begin
                    val_next[j] = VAL_MAX;
                    sat_next    = 1'b1;
                end
                else
                begin
                    val_next[j] = in_res.q[j];
                end
            end
            else
            begin
                if (in_res.ovf[j] || (in_res.q[j][QW-1] && (in_res.q[j][QW-2:0] != '0)))
                begin
                    val_next[j] = VAL_MIN;
                    sat_next    = 1'b1;
                end
                else
                begin
                    val_next[j] = QW'(0) - in_res.q[j];
                end
            end
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            val_reg   <= val_next;
            degen_reg <= in_res.degen;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_val   = val_reg;
    assign out_degen = degen_reg;
    assign out_sat   = sat_reg;

endmodule

// ===== rtl/core/triangle_affine_solve_and_map_top.sv =====
// ----------------------------------------------------------------------------
// triangle_affine_solve_and_map_top
// affine map between a stored basis triangle and a target, solve or apply
// ----------------------------------------------------------------------------
// channels: s_* takes one request per accepted beat, m_* returns one result
// per request in the same order, cfg_* writes the six basis coordinates
// solve (s_tuser 0): tdata is the target triangle, result is a, -d, -b, e,
// c, -f; a basis with zero determinant gives zeros and the degenerate flag
// map (s_tuser 1): tdata is six coefficients, result is the mapped basis
// results are rounded to nearest, ties away from zero, and clamped to 32 bits
// pipeline: 6 arithmetic stages, 33 divider stages and an output register
// throughput: one request per cycle while the output is not stalled; the
// divider is an overflow check stage, then a stage per quotient bit
// stall: when m_tready is low stages fill bubbles first, then s_tready drops;
// nothing is lost or repeated; with m_tready high s_tready stays high
// reset: pipeline empties, basis returns to (0,0), (1,0), (0,1)
// basis writes are taken at any time but belong only to an empty pipeline
// ----------------------------------------------------------------------------
module triangle_affine_solve_and_map_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tasm_pkg::DATA_W-1:0]      s_tdata,   // in_val0 .. in_val5
    input  logic                             s_tuser,   // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tasm_pkg::DATA_W-1:0]      m_tdata,   // out_val0 .. out_val5
    output logic [1:0]                       m_tuser,   // degenerate, saturated
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tasm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tasm_pkg::VW-1:0]          cfg_data
);
    import tasm_pkg::*;

    basis_t   basis_reg;
    basis_t   basis_next;
    req_t     req;
    val_vec_t val_in;
    val_vec_t val_out;
    logic     f_valid;
    logic     f_ready;
    div_req_t f_req;
    logic     d_valid;
    logic     d_ready;
    div_res_t d_res;
    logic     degen;
    logic     sat;

    always_comb
    begin
        basis_next = basis_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_A_X: basis_next.ax = cfg_data;
                REG_A_Y: basis_next.ay = cfg_data;
                REG_B_X: basis_next.bx = cfg_data;
                REG_B_Y: basis_next.by = cfg_data;
                REG_C_X: basis_next.cx = cfg_data;
                REG_C_Y: basis_next.cy = cfg_data;
                default: basis_next = basis_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_reg <= BASIS_RST;
        end
        else
        begin
            basis_reg <= basis_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign req       = req_t'(s_tuser);
    assign val_in    = s_tdata;

    tasm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (req),
        .in_val    (val_in),
        .basis     (basis_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_req   (f_req)
    );

    tasm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_req    (f_req),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_res   (d_res)
    );

    tasm_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_res    (d_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_val   (val_out),
        .out_degen (degen),
        .out_sat   (sat)
    );

    assign m_tdata = val_out;
    assign m_tuser = {sat, degen};

endmodule

// ===== rtl/core/tasm_check.sv =====
// ----------------------------------------------------------------------------
// tasm_check
// port level checks for the triangle affine solve and map block
// ----------------------------------------------------------------------------
module tasm_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tasm_pkg::DATA_W-1:0]      m_tdata,
    input logic [1:0]                       m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // degenerate basis gives zeros and no clamp
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("degenerate result not cleared");

    // a free receiver never blocks requests
    a_flow: assert property (@(posedge clk)
        m_tready |-> s_tready)
        else $error("request blocked with receiver ready");

    // reset empties the output
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid in reset");

endmodule

bind triangle_affine_solve_and_map_top tasm_check u_check (.*);
